// File: design/mpbm_pkg.sv
// Shared constants, codes and controller/datapath interface types for the byte matcher.
package mpbm_pkg;

	localparam int MAX_NODES       = 1024;
	localparam int NODE_W          = $clog2(MAX_NODES);
	localparam int NCNT_W          = NODE_W + 1;
	localparam int TT_DEPTH        = MAX_NODES * 256;
	localparam int TT_AW           = $clog2(TT_DEPTH);
	localparam int MAX_PATTERNS    = 64;
	localparam int PID_W           = 6;
	localparam int PLINK_W         = PID_W + 1;
	localparam logic [PLINK_W-1:0] NO_PAT = PLINK_W'(MAX_PATTERNS);
	localparam int MAX_PATTERN_LEN = 256;
	localparam int LEN_W           = 9;
	localparam logic [LEN_W-1:0] LEN_MAX    = LEN_W'(MAX_PATTERN_LEN);
	localparam logic [LEN_W-1:0] LEN_POISON = LEN_W'(MAX_PATTERN_LEN + 1);
	localparam int POS_W           = 48;
	localparam int START_W         = POS_W + 1;
	localparam int RCNT_W          = 7;
	localparam int NW_W            = 2 * PLINK_W;

	localparam logic [1:0] REQ_ADD   = 2'd0;
	localparam logic [1:0] REQ_BUILD = 2'd1;
	localparam logic [1:0] REQ_SCAN  = 2'd2;

	localparam logic [1:0] KIND_MATCH   = 2'd0;
	localparam logic [1:0] KIND_STORED  = 2'd1;
	localparam logic [1:0] KIND_REFUSED = 2'd2;
	localparam logic [1:0] KIND_BUILT   = 2'd3;

	typedef enum logic [4:0] {
		CMD_IDLE, CMD_CLR,
		CMD_ADD0, CMD_ADD1, CMD_ADD2, CMD_ADD3, CMD_ADD4,
		CMD_BINIT, CMD_BR0, CMD_BR1,
		CMD_BU0, CMD_BU1, CMD_BU2, CMD_BU3,
		CMD_BC0, CMD_BC1, CMD_BC2,
		CMD_BFIN, CMD_BDONE,
		CMD_S0, CMD_S1, CMD_N0, CMD_N1, CMD_P0, CMD_P1,
		CMD_FIN
	} cmd_t;

	typedef struct packed {
		logic       clr_last;
		logic [1:0] in_req;
		logic       built;
		logic       in_end;
		logic       c_last;
		logic       q_more;
		logic       p_ok;
		logic       link_ok;
		logic       blocked;
	} stat_t;

endpackage

// File: design/mpbm_ram.sv
// Generic simple dual-port RAM with registered read.
module mpbm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: design/mpbm_ctrl.sv
// Sequencing state machine for insert, build and scan transactions.
module mpbm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	input  mpbm_pkg::stat_t st,
	output mpbm_pkg::cmd_t  cmd
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_CLR,
		ST_ADD0, ST_ADD1, ST_ADD2, ST_ADD3, ST_ADD4,
		ST_BINIT, ST_BR0, ST_BR1,
		ST_BU0, ST_BU1, ST_BU2, ST_BU3,
		ST_BC0, ST_BC1, ST_BC2,
		ST_BFIN, ST_BDONE,
		ST_S0, ST_S1, ST_N0, ST_N1, ST_P0, ST_P1,
		ST_FIN
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			unique case (state_q)
				ST_CLR: begin
					if (st.clr_last) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						unique case (st.in_req)
							mpbm_pkg::REQ_ADD:   state_q <= ST_ADD0;
							mpbm_pkg::REQ_BUILD: state_q <= st.built ? ST_BDONE : ST_BINIT;
							mpbm_pkg::REQ_SCAN:  state_q <= ST_S0;
							default:             state_q <= ST_IDLE;
						endcase
					end
				end
				ST_ADD0: state_q <= ST_ADD1;
				ST_ADD1: state_q <= st.in_end ? ST_ADD2 : ST_FIN;
				ST_ADD2: state_q <= ST_ADD3;
				ST_ADD3: state_q <= ST_ADD4;
				ST_ADD4: state_q <= ST_FIN;
				ST_BINIT: state_q <= ST_BR0;
				ST_BR0: state_q <= ST_BR1;
				ST_BR1: begin
					if (!st.c_last) state_q <= ST_BR0;
					else state_q <= st.q_more ? ST_BU0 : ST_BFIN;
				end
				ST_BU0: state_q <= ST_BU1;
				ST_BU1: state_q <= ST_BU2;
				ST_BU2: state_q <= ST_BU3;
				ST_BU3: state_q <= ST_BC0;
				ST_BC0: state_q <= ST_BC1;
				ST_BC1: state_q <= ST_BC2;
				ST_BC2: begin
					if (!st.c_last) state_q <= ST_BC0;
					else state_q <= st.q_more ? ST_BU0 : ST_BFIN;
				end
				ST_BFIN: state_q <= ST_FIN;
				ST_BDONE: state_q <= ST_FIN;
				ST_S0: state_q <= st.built ? ST_S1 : ST_FIN;
				ST_S1: state_q <= ST_N0;
				ST_N0: state_q <= ST_N1;
				ST_N1: state_q <= ST_P0;
				ST_P0: begin
					priority if (st.p_ok) state_q <= ST_P1;
					else if (st.link_ok) state_q <= ST_N0;
					else state_q <= ST_FIN;
				end
				ST_P1: begin
					if (!st.blocked) state_q <= ST_P0;
				end
				ST_FIN: begin
					if (!st.blocked) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		unique case (state_q)
			ST_IDLE:  cmd = mpbm_pkg::CMD_IDLE;
			ST_CLR:   cmd = mpbm_pkg::CMD_CLR;
			ST_ADD0:  cmd = mpbm_pkg::CMD_ADD0;
			ST_ADD1:  cmd = mpbm_pkg::CMD_ADD1;
			ST_ADD2:  cmd = mpbm_pkg::CMD_ADD2;
			ST_ADD3:  cmd = mpbm_pkg::CMD_ADD3;
			ST_ADD4:  cmd = mpbm_pkg::CMD_ADD4;
			ST_BINIT: cmd = mpbm_pkg::CMD_BINIT;
			ST_BR0:   cmd = mpbm_pkg::CMD_BR0;
			ST_BR1:   cmd = mpbm_pkg::CMD_BR1;
			ST_BU0:   cmd = mpbm_pkg::CMD_BU0;
			ST_BU1:   cmd = mpbm_pkg::CMD_BU1;
			ST_BU2:   cmd = mpbm_pkg::CMD_BU2;
			ST_BU3:   cmd = mpbm_pkg::CMD_BU3;
			ST_BC0:   cmd = mpbm_pkg::CMD_BC0;
			ST_BC1:   cmd = mpbm_pkg::CMD_BC1;
			ST_BC2:   cmd = mpbm_pkg::CMD_BC2;
			ST_BFIN:  cmd = mpbm_pkg::CMD_BFIN;
			ST_BDONE: cmd = mpbm_pkg::CMD_BDONE;
			ST_S0:    cmd = mpbm_pkg::CMD_S0;
			ST_S1:    cmd = mpbm_pkg::CMD_S1;
			ST_N0:    cmd = mpbm_pkg::CMD_N0;
			ST_N1:    cmd = mpbm_pkg::CMD_N1;
			ST_P0:    cmd = mpbm_pkg::CMD_P0;
			ST_P1:    cmd = mpbm_pkg::CMD_P1;
			ST_FIN:   cmd = mpbm_pkg::CMD_FIN;
			default:  cmd = mpbm_pkg::CMD_IDLE;
		endcase
	end

endmodule

// File: design/mpbm_dp.sv
// Datapath: automaton memories, insert/build/scan registers and the result output stage.
module mpbm_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  mpbm_pkg::cmd_t  cmd,
	output mpbm_pkg::stat_t st,
	input  logic            s_tvalid,
	input  logic [63:0]     s_tdata,
	input  logic [1:0]      s_tuser,
	input  logic            s_tlast,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [55:0]     m_tdata,
	output logic [1:0]      m_tuser,
	output logic            m_tlast
);

	localparam int NW = mpbm_pkg::NODE_W;
	localparam int PW = mpbm_pkg::PLINK_W;

	// captured transaction
	logic [7:0]                    byte_q;
	logic [mpbm_pkg::PID_W-1:0]    id_q;
	logic                          end_q;
	logic [mpbm_pkg::POS_W-1:0]    pos_q;
	logic                          rst_q;

	logic [mpbm_pkg::TT_AW-1:0]    clr_q;
	logic [mpbm_pkg::NCNT_W-1:0]   node_cnt_q;
	logic [NW-1:0]                 ins_node_q;
	logic [mpbm_pkg::LEN_W-1:0]    ins_len_q;
	logic [NW-1:0]                 scan_q;
	logic                          built_q;
	logic                          rd_q;
	logic                          ok_q;
	logic                          empty_q;
	logic [PW-1:0]                 last_q;

	logic [mpbm_pkg::NCNT_W-1:0]   head_q, tail_q, tail_n;
	logic [NW-1:0]                 u_q, f_q, v_q, cur_q, link_q;
	logic [7:0]                    c_q;
	logic [PW-1:0]                 p_q;
	logic [mpbm_pkg::RCNT_W-1:0]   k_q;

	logic                          pend_valid_q;
	logic [1:0]                    pend_kind_q;
	logic [mpbm_pkg::START_W-1:0]  pend_start_q;
	logic [mpbm_pkg::PID_W-1:0]    pend_id_q;

	logic                          m_valid_q;
	logic [1:0]                    m_kind_q;
	logic [mpbm_pkg::START_W-1:0]  m_start_q;
	logic [mpbm_pkg::PID_W-1:0]    m_id_q;
	logic                          m_last_q;

	// memory ports
	logic                        tt_we;
	logic [mpbm_pkg::TT_AW-1:0]  tt_waddr, tt_raddr;
	logic [NW-1:0]               tt_wdata, tt_rdata;
	logic                        fl_we;
	logic [NW-1:0]               fl_waddr, fl_wdata, fl_raddr, fl_rdata;
	logic                        ol_we;
	logic [NW-1:0]               ol_waddr, ol_wdata, ol_raddr, ol_rdata;
	logic                        q_we;
	logic [NW-1:0]               q_waddr, q_wdata, q_rdata;
	logic                        nw_we;
	logic [NW-1:0]               nw_waddr, nw_raddr;
	logic [mpbm_pkg::NW_W-1:0]   nw_wdata, nw_rdata;
	logic                        pl_we;
	logic [mpbm_pkg::PID_W-1:0]  pl_waddr, pl_raddr;
	logic [mpbm_pkg::LEN_W-1:0]  pl_wdata, pl_rdata;
	logic                        pn_we;
	logic [mpbm_pkg::PID_W-1:0]  pn_waddr;
	logic [PW-1:0]               pn_wdata, pn_rdata;

	logic [NW-1:0]               scan_eff;
	logic [PW-1:0]               nw_first, nw_last;
	logic                        push;
	logic                        ok;
	logic                        out_busy;
	logic                        blocked;
	logic                        produce;
	logic                        flush;
	logic [mpbm_pkg::START_W-1:0] match_start;

	assign scan_eff = rst_q ? '0 : scan_q;
	assign nw_first = nw_rdata[mpbm_pkg::NW_W-1:PW];
	assign nw_last  = nw_rdata[PW-1:0];
	assign out_busy = m_valid_q && !m_tready;
	assign blocked  = pend_valid_q && out_busy;
	assign produce  = (cmd == mpbm_pkg::CMD_P1) && !blocked;
	assign flush    = (cmd == mpbm_pkg::CMD_FIN) && pend_valid_q && !out_busy;
	assign match_start = {1'b0, pos_q}
		- {{(mpbm_pkg::START_W - mpbm_pkg::LEN_W){1'b0}}, pl_rdata}
		+ mpbm_pkg::START_W'(1);

	assign ok = !built_q && (ins_len_q != '0) && (ins_len_q <= mpbm_pkg::LEN_MAX)
		&& (pl_rdata == '0);

	// queue push during root sweep and child sweep
	always_comb begin
		push = 1'b0;
		if (cmd == mpbm_pkg::CMD_BR1) push = (tt_rdata != '0) && !tail_q[NW];
		if (cmd == mpbm_pkg::CMD_BC2) push = (v_q != '0) && !tail_q[NW];
	end
	assign tail_n = tail_q + {{NW{1'b0}}, push};

	assign st.clr_last = &clr_q;
	assign st.in_req   = s_tuser;
	assign st.built    = built_q;
	assign st.in_end   = end_q;
	assign st.c_last   = &c_q;
	assign st.q_more   = head_q < tail_n;
	assign st.p_ok     = !p_q[PW-1] && !k_q[mpbm_pkg::RCNT_W-1];
	assign st.link_ok  = (link_q != '0) && !k_q[mpbm_pkg::RCNT_W-1];
	assign st.blocked  = blocked;

	// read addresses
	always_comb begin
		unique case (cmd)
			mpbm_pkg::CMD_BR0: tt_raddr = {{NW{1'b0}}, c_q};
			mpbm_pkg::CMD_BC0: tt_raddr = {u_q, c_q};
			mpbm_pkg::CMD_BC1: tt_raddr = {f_q, c_q};
			mpbm_pkg::CMD_S0:  tt_raddr = {scan_eff, byte_q};
			default:           tt_raddr = {ins_node_q, byte_q};
		endcase
		fl_raddr = q_rdata;
		ol_raddr = (cmd == mpbm_pkg::CMD_BU2) ? fl_rdata : cur_q;
		unique case (cmd)
			mpbm_pkg::CMD_BU2:  nw_raddr = fl_rdata;
			mpbm_pkg::CMD_ADD2: nw_raddr = ins_node_q;
			default:            nw_raddr = cur_q;
		endcase
		pl_raddr = (cmd == mpbm_pkg::CMD_ADD2) ? id_q : p_q[mpbm_pkg::PID_W-1:0];
	end

	// write ports
	always_comb begin
		tt_we = 1'b0; tt_waddr = clr_q; tt_wdata = '0;
		fl_we = 1'b0; fl_waddr = '0; fl_wdata = '0;
		ol_we = 1'b0; ol_waddr = '0; ol_wdata = '0;
		q_we  = 1'b0; q_waddr = tail_q[NW-1:0]; q_wdata = v_q;
		nw_we = 1'b0; nw_waddr = clr_q[NW-1:0]; nw_wdata = {mpbm_pkg::NO_PAT, mpbm_pkg::NO_PAT};
		pl_we = 1'b0; pl_waddr = clr_q[mpbm_pkg::PID_W-1:0]; pl_wdata = '0;
		pn_we = 1'b0; pn_waddr = id_q; pn_wdata = mpbm_pkg::NO_PAT;
		unique case (cmd)
			mpbm_pkg::CMD_CLR: begin
				tt_we = 1'b1;
				nw_we = (clr_q[mpbm_pkg::TT_AW-1:NW] == '0);
				pl_we = (clr_q[mpbm_pkg::TT_AW-1:mpbm_pkg::PID_W] == '0);
			end
			mpbm_pkg::CMD_ADD1: begin
				tt_waddr = {ins_node_q, byte_q};
				tt_wdata = node_cnt_q[NW-1:0];
				tt_we    = rd_q && (tt_rdata == '0) && !node_cnt_q[NW];
			end
			mpbm_pkg::CMD_ADD3: begin
				nw_waddr = ins_node_q;
				nw_wdata = (nw_first == mpbm_pkg::NO_PAT) ? {{1'b0, id_q}, {1'b0, id_q}}
					: {nw_first, {1'b0, id_q}};
				nw_we    = ok;
				pl_waddr = id_q;
				pl_wdata = ins_len_q;
				pl_we    = ok;
				pn_we    = ok;
			end
			mpbm_pkg::CMD_ADD4: begin
				// link previous tail of this node's list to the new id
				pn_waddr = last_q[mpbm_pkg::PID_W-1:0];
				pn_wdata = {1'b0, id_q};
				pn_we    = ok_q && !empty_q;
			end
			mpbm_pkg::CMD_BINIT: begin
				fl_we = 1'b1;
				ol_we = 1'b1;
			end
			mpbm_pkg::CMD_BR1: begin
				fl_waddr = tt_rdata;
				fl_we    = push;
				q_wdata  = tt_rdata;
				q_we     = push;
			end
			mpbm_pkg::CMD_BU3: begin
				ol_waddr = u_q;
				ol_wdata = (nw_first != mpbm_pkg::NO_PAT) ? f_q : ol_rdata;
				ol_we    = 1'b1;
			end
			mpbm_pkg::CMD_BC2: begin
				tt_waddr = {u_q, c_q};
				tt_wdata = tt_rdata;
				tt_we    = (v_q == '0);
				fl_waddr = v_q;
				fl_wdata = tt_rdata;
				fl_we    = push;
				q_we     = push;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0; id_q <= '0; end_q <= 1'b0; pos_q <= '0; rst_q <= 1'b0;
			clr_q <= '0;
			node_cnt_q <= mpbm_pkg::NCNT_W'(1);
			ins_node_q <= '0; ins_len_q <= '0; scan_q <= '0; built_q <= 1'b0;
			rd_q <= 1'b0; ok_q <= 1'b0; empty_q <= 1'b0; last_q <= '0;
			head_q <= '0; tail_q <= '0;
			u_q <= '0; f_q <= '0; v_q <= '0; cur_q <= '0; link_q <= '0;
			c_q <= '0; p_q <= mpbm_pkg::NO_PAT; k_q <= '0;
			pend_valid_q <= 1'b0; pend_kind_q <= '0; pend_start_q <= '0; pend_id_q <= '0;
			m_valid_q <= 1'b0; m_kind_q <= '0; m_start_q <= '0; m_id_q <= '0;
			m_last_q <= 1'b0;
		end else begin
			// output stage: a new transaction replaces a taken one
			if (produce && pend_valid_q) begin
				m_valid_q <= 1'b1;
				m_kind_q  <= pend_kind_q;
				m_start_q <= pend_start_q;
				m_id_q    <= pend_id_q;
				m_last_q  <= 1'b0;
			end else if (flush) begin
				m_valid_q <= 1'b1;
				m_kind_q  <= pend_kind_q;
				m_start_q <= pend_start_q;
				m_id_q    <= pend_id_q;
				m_last_q  <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (cmd)
				mpbm_pkg::CMD_CLR: clr_q <= clr_q + 1'b1;
				mpbm_pkg::CMD_IDLE: begin
					if (s_tvalid) begin
						byte_q <= s_tdata[7:0];
						id_q   <= s_tdata[13:8];
						pos_q  <= s_tdata[61:14];
						rst_q  <= s_tdata[62];
						end_q  <= s_tlast;
					end
				end
				mpbm_pkg::CMD_ADD0: begin
					rd_q <= !built_q && (ins_len_q < mpbm_pkg::LEN_MAX);
					if (!built_q && ins_len_q == mpbm_pkg::LEN_MAX)
						ins_len_q <= mpbm_pkg::LEN_POISON;
				end
				mpbm_pkg::CMD_ADD1: begin
					if (rd_q) begin
						if (tt_rdata != '0) begin
							ins_node_q <= tt_rdata;
							ins_len_q  <= ins_len_q + 1'b1;
						end else if (node_cnt_q[NW]) begin
							ins_len_q <= mpbm_pkg::LEN_POISON;
						end else begin
							node_cnt_q <= node_cnt_q + 1'b1;
							ins_node_q <= node_cnt_q[NW-1:0];
							ins_len_q  <= ins_len_q + 1'b1;
						end
					end
				end
				mpbm_pkg::CMD_ADD3: begin
					ok_q    <= ok;
					empty_q <= (nw_first == mpbm_pkg::NO_PAT);
					last_q  <= nw_last;
				end
				mpbm_pkg::CMD_ADD4: begin
					pend_valid_q <= 1'b1;
					pend_kind_q  <= ok_q ? mpbm_pkg::KIND_STORED : mpbm_pkg::KIND_REFUSED;
					pend_start_q <= '0;
					pend_id_q    <= id_q;
					ins_node_q   <= '0;
					ins_len_q    <= '0;
				end
				mpbm_pkg::CMD_BINIT: begin
					head_q <= '0; tail_q <= '0; c_q <= '0;
				end
				mpbm_pkg::CMD_BR1: begin
					tail_q <= tail_n;
					c_q    <= c_q + 1'b1;
				end
				mpbm_pkg::CMD_BU1: begin
					u_q    <= q_rdata;
					head_q <= head_q + 1'b1;
				end
				mpbm_pkg::CMD_BU2: f_q <= fl_rdata;
				mpbm_pkg::CMD_BU3: c_q <= '0;
				mpbm_pkg::CMD_BC1: v_q <= tt_rdata;
				mpbm_pkg::CMD_BC2: begin
					tail_q <= tail_n;
					c_q    <= c_q + 1'b1;
				end
				mpbm_pkg::CMD_BFIN, mpbm_pkg::CMD_BDONE: begin
					built_q      <= 1'b1;
					pend_valid_q <= 1'b1;
					pend_kind_q  <= mpbm_pkg::KIND_BUILT;
					pend_start_q <= '0;
					pend_id_q    <= '0;
				end
				mpbm_pkg::CMD_S0: scan_q <= scan_eff;
				mpbm_pkg::CMD_S1: begin
					scan_q <= tt_rdata;
					cur_q  <= tt_rdata;
					k_q    <= '0;
				end
				mpbm_pkg::CMD_N1: begin
					p_q    <= nw_first;
					link_q <= ol_rdata;
				end
				mpbm_pkg::CMD_P0: begin
					if (!st.p_ok && st.link_ok) cur_q <= link_q;
				end
				mpbm_pkg::CMD_P1: begin
					if (!blocked) begin
						pend_valid_q <= 1'b1;
						pend_kind_q  <= mpbm_pkg::KIND_MATCH;
						pend_start_q <= match_start;
						pend_id_q    <= p_q[mpbm_pkg::PID_W-1:0];
						p_q          <= pn_rdata;
						k_q          <= k_q + 1'b1;
					end
				end
				mpbm_pkg::CMD_FIN: begin
					// flush the held result as the final one of this transaction
					if (flush) pend_valid_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_kind_q;
	assign m_tlast  = m_last_q;
	assign m_tdata  = {1'b0, m_id_q, m_start_q};

	mpbm_ram #(.WIDTH(NW), .DEPTH(mpbm_pkg::TT_DEPTH)) u_tt (
		.clk(clk), .we(tt_we), .waddr(tt_waddr), .wdata(tt_wdata),
		.raddr(tt_raddr), .rdata(tt_rdata));
	mpbm_ram #(.WIDTH(NW), .DEPTH(mpbm_pkg::MAX_NODES)) u_fail (
		.clk(clk), .we(fl_we), .waddr(fl_waddr), .wdata(fl_wdata),
		.raddr(fl_raddr), .rdata(fl_rdata));
	mpbm_ram #(.WIDTH(NW), .DEPTH(mpbm_pkg::MAX_NODES)) u_olink (
		.clk(clk), .we(ol_we), .waddr(ol_waddr), .wdata(ol_wdata),
		.raddr(ol_raddr), .rdata(ol_rdata));
	mpbm_ram #(.WIDTH(NW), .DEPTH(mpbm_pkg::MAX_NODES)) u_queue (
		.clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
		.raddr(head_q[NW-1:0]), .rdata(q_rdata));
	mpbm_ram #(.WIDTH(mpbm_pkg::NW_W), .DEPTH(mpbm_pkg::MAX_NODES)) u_nodepat (
		.clk(clk), .we(nw_we), .waddr(nw_waddr), .wdata(nw_wdata),
		.raddr(nw_raddr), .rdata(nw_rdata));
	mpbm_ram #(.WIDTH(mpbm_pkg::LEN_W), .DEPTH(mpbm_pkg::MAX_PATTERNS)) u_plen (
		.clk(clk), .we(pl_we), .waddr(pl_waddr), .wdata(pl_wdata),
		.raddr(pl_raddr), .rdata(pl_rdata));
	mpbm_ram #(.WIDTH(PW), .DEPTH(mpbm_pkg::MAX_PATTERNS)) u_pnext (
		.clk(clk), .we(pn_we), .waddr(pn_waddr), .wdata(pn_wdata),
		.raddr(p_q[mpbm_pkg::PID_W-1:0]), .rdata(pn_rdata));

endmodule

// File: design/multi_pattern_byte_matcher.sv
// Aho-Corasick multi-pattern byte matcher top level.
// Input channel s_*: one request per transaction; s_tuser holds the request type
// (pattern byte, build, scan byte), s_tlast marks the last byte of a pattern.
// Output channel m_*: one result per transaction; m_tuser holds the result kind,
// m_tlast marks the final result caused by one request.
// After reset a clearing pass wipes the transition table and the per-node and
// per-pattern lists; s_tready stays low during it.
// One request is worked at a time, s_tready is high only while the sequencer idles.
// Request duration is set by the single read port of each memory:
//   pattern byte: extra pattern-list update steps when it carries the end mark
//   build: a sweep of the root's byte values, then per trie node three table
//   reads/writes per byte value through the one table port; skipped if already built
//   scan byte: grows with each reported match and each output-link node visited;
//   no table lookup before the build
// A request is taken while the last result of the previous one still sits in the
// output register. A stalled receiver holds the sequencer at its next result.
module multi_pattern_byte_matcher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // data_byte, pattern_id, position, restart, pad
	input  logic [1:0]  s_tuser,  // req_type
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // match_start, matched_id, pad
	output logic [1:0]  m_tuser,  // result_kind
	output logic        m_tlast
);

	mpbm_pkg::cmd_t  cmd;
	mpbm_pkg::stat_t st;

	assign s_tready = (cmd == mpbm_pkg::CMD_IDLE);

	mpbm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .st(st), .cmd(cmd));

	mpbm_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .st(st),
		.s_tvalid(s_tvalid), .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast));

endmodule
